// ===== rtl/wsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weight stability detector package
// Shared widths, register indexes, reset values, request types and the control struct for the min/max unit.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int unsigned WEIGHT_W  = 24;
  localparam int unsigned CFG_W     = 23;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SPREAD_W  = WEIGHT_W + 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STABLE_BAND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] CAPACITY_RST    = 23'h7F_FFFF;
  localparam logic [CFG_W-1:0] STABLE_BAND_RST = 23'd10;
  localparam logic [LEN_W-1:0] WINDOW_LEN_RST  = 5'd8;

  // request types
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TARE   = 1'b1;

  // min/max unit control
  typedef struct packed {
    logic load;   // a window entry is presented this cycle
    logic first;  // it is the first entry of the scan
  } mm_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/wsd_minmax.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Window min/max tracker
// Folds one window entry per cycle, while load is set, into a running minimum and maximum and
// reports whether the spread between them lies within the stable band.
// ----------------------------------------------------------------------------
module wsd_minmax (
  input  wire                                clk_i,
  input  wsd_pkg::mm_ctl_t                   ctl_i,
  input  wire signed [wsd_pkg::WEIGHT_W-1:0] sample_i,
  input  wire        [wsd_pkg::CFG_W-1:0]    band_i,
  output logic                               stable_o
);
  import wsd_pkg::*;

  logic signed [WEIGHT_W-1:0] lo_q, hi_q;
  logic signed [SPREAD_W-1:0] spread;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      if (ctl_i.first) begin
        lo_q <= sample_i;
        hi_q <= sample_i;
      end else begin
        if (sample_i < lo_q) lo_q <= sample_i;
        if (sample_i > hi_q) hi_q <= sample_i;
      end
    end
  end

  // hi never falls below lo, so the spread is non-negative
  assign spread   = {hi_q[WEIGHT_W-1], hi_q} - {lo_q[WEIGHT_W-1], lo_q};
  assign stable_o = $unsigned(spread) <= {{(SPREAD_W - CFG_W){1'b0}}, band_i};

endmodule
`default_nettype wire

// ===== rtl/weight_stability_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weight stability detector
// Input channel (in_valid_i/in_ready_o) carries a request type and a signed
// weight in 0.1 g units. A tare clears the fill count and gives no result.
// A sample above capacity gives a result flagged overload and clears the fill
// count. Any other sample is written to a circular window; once the window is
// full, the window is scanned for its minimum and maximum and the sample is
// flagged stable when the spread is within the stable band.
// Output channel (out_valid_o/out_ready_i) carries one result per sample.
// Sequence: a tare completes in the idle state; an overload or a sample with a
// part-filled window goes straight to the output state; a sample with a full
// window first scans the effective window length, one window entry per cycle,
// from the sample memory. The block takes one request at a time and stays
// not ready until the result is loaded into the output register; a stalled
// receiver holds the block in its output state. Reset restores the register
// defaults and clears pointer, fill count and output valid; the sample memory
// is not cleared. Configuration writes (cfg_we_i) take effect at once; the
// user must write them only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module weight_stability_detector #(
  parameter int unsigned WINDOW_DEPTH = 16
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire        [wsd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire        [wsd_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire                                 req_type_i,
  input  wire signed [wsd_pkg::WEIGHT_W-1:0]  weight_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic signed [wsd_pkg::WEIGHT_W-1:0] weight_out_o,
  output logic                                overload_o,
  output logic                                stable_o
);
  import wsd_pkg::*;

  localparam int unsigned PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CMP_W = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(WINDOW_DEPTH);
  localparam logic [CMP_W-1:0] ONE_C   = CMP_W'(1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  // configuration
  logic [CFG_W-1:0] cap_q, band_q;
  logic [LEN_W-1:0] wl_q;

  // window bookkeeping
  logic [PTR_W-1:0] wp_q, wp_d;
  logic [LEN_W-1:0] fill_q, fill_d;
  logic [CMP_W-1:0] eff_len, wp_ext, wp_eff, wp_inc, wp_nxt, fill_ext, fill_inc;

  // sequencer
  logic [1:0]       state_q, state_d;
  logic [CMP_W-1:0] idx_q, idx_d;
  logic             rvalid_q, rfirst_q;
  logic             scan_q, scan_d;
  logic             ovl_q, ovl_d;
  logic signed [WEIGHT_W-1:0] w_q;
  logic             out_valid_q;

  // sample memory
  logic signed [WEIGHT_W-1:0] mem [WINDOW_DEPTH];
  logic signed [WEIGHT_W-1:0] rdata_q;

  logic in_xfer, is_sample, over, mem_we, rd_en, out_load, out_valid_d;
  logic mm_stable;
  mm_ctl_t mm_ctl;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign is_sample  = (req_type_i == REQ_SAMPLE);
  assign over       = $signed({weight_i[WEIGHT_W-1], weight_i})
                      > $signed({2'b00, cap_q});
  assign mem_we     = in_xfer && is_sample && !over;

  // effective window length: zero acts as one, clamp to the store depth
  always_comb begin
    if (wl_q == '0) begin
      eff_len = ONE_C;
    end else if (CMP_W'(wl_q) > DEPTH_C) begin
      eff_len = DEPTH_C;
    end else begin
      eff_len = CMP_W'(wl_q);
    end
  end

  assign wp_ext   = CMP_W'(wp_q);
  assign wp_eff   = (wp_ext >= eff_len) ? '0 : wp_ext;
  assign wp_inc   = wp_eff + ONE_C;
  assign wp_nxt   = (wp_inc == eff_len) ? '0 : wp_inc;
  assign fill_ext = CMP_W'(fill_q);
  assign fill_inc = (fill_ext < eff_len) ? fill_ext + ONE_C : fill_ext;

  assign rd_en    = (state_q == S_SCAN) && (idx_q < eff_len);
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    scan_d  = scan_q;
    ovl_d   = ovl_q;
    wp_d    = wp_q;
    fill_d  = fill_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (!is_sample) begin
            fill_d = '0;
          end else if (over) begin
            fill_d  = '0;
            ovl_d   = 1'b1;
            scan_d  = 1'b0;
            state_d = S_OUT;
          end else begin
            wp_d   = wp_nxt[PTR_W-1:0];
            fill_d = fill_inc[LEN_W-1:0];
            ovl_d  = 1'b0;
            idx_d  = '0;
            if (fill_inc >= eff_len) begin
              scan_d  = 1'b1;
              state_d = S_SCAN;
            end else begin
              scan_d  = 1'b0;
              state_d = S_OUT;
            end
          end
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          idx_d = idx_q + ONE_C;
        end else if (!rvalid_q) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    // a new window length restarts the window
    if (cfg_we_i && cfg_idx_i == REG_WINDOW_LEN && cfg_data_i[LEN_W-1:0] != wl_q) begin
      wp_d   = '0;
      fill_d = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAPACITY_RST;
      band_q      <= STABLE_BAND_RST;
      wl_q        <= WINDOW_LEN_RST;
      wp_q        <= '0;
      fill_q      <= '0;
      state_q     <= S_IDLE;
      idx_q       <= '0;
      rvalid_q    <= 1'b0;
      rfirst_q    <= 1'b0;
      scan_q      <= 1'b0;
      ovl_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CAPACITY:    cap_q  <= cfg_data_i;
          REG_STABLE_BAND: band_q <= cfg_data_i;
          REG_WINDOW_LEN:  wl_q   <= cfg_data_i[LEN_W-1:0];
          default: ;
        endcase
      end
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      state_q     <= state_d;
      idx_q       <= idx_d;
      rvalid_q    <= rd_en;
      rfirst_q    <= rd_en && (idx_q == '0);
      scan_q      <= scan_d;
      ovl_q       <= ovl_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload: hold the sample for the echo, load results on transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) w_q <= weight_i;
    if (out_load) begin
      weight_out_o <= w_q;
      overload_o   <= ovl_q;
      stable_o     <= scan_q && mm_stable;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wp_eff[PTR_W-1:0]] <= weight_i;
    if (rd_en)  rdata_q <= mem[idx_q[PTR_W-1:0]];
  end

  assign mm_ctl.load  = rvalid_q;
  assign mm_ctl.first = rfirst_q;

  wsd_minmax u_minmax (
    .clk_i    (clk_i),
    .ctl_i    (mm_ctl),
    .sample_i (rdata_q),
    .band_i   (band_q),
    .stable_o (mm_stable)
  );

  assign out_valid_o = out_valid_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(fill_q) <= eff_len)
    else $error("fill count exceeds window length");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(wp_q) < eff_len)
    else $error("write pointer outside window");

  a_scan_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> idx_q <= eff_len)
    else $error("scan index ran past window");

  a_ovl_not_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overload_o |-> !stable_o)
    else $error("overload result reported stable");

  a_scan_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> CMP_W'(fill_q) == eff_len)
    else $error("scan started on a window that is not full");

endmodule
`default_nettype wire

// ===== tb/sv/weight_stability_detector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weight stability detector testbench
// Drives tare events and weight samples through the request channel under
// several register settings and idle patterns. A scoreboard predicts the
// overload and stable flags from its own copy of the window and compares
// every result with the oldest prediction.
// ----------------------------------------------------------------------------
module weight_stability_detector_tb;
  import wsd_pkg::*;

  localparam int unsigned WINDOW_SLOTS = 16;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned PHASE_COUNT = 12;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam int unsigned DIRECTED_COUNT = 22;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight;
    logic                       overload;
    logic                       stable;
  } reading_t;

  class stability_scoreboard;
    logic [CFG_W-1:0]           capacity;
    logic [CFG_W-1:0]           band;
    logic [LEN_W-1:0]           win_len;
    logic signed [WEIGHT_W-1:0] window [WINDOW_SLOTS];
    int unsigned                wr_ptr;
    int unsigned                fill;
    reading_t                   expected [$];
    int unsigned                errors;

    function void clear();
      capacity = CAPACITY_RST;
      band     = STABLE_BAND_RST;
      win_len  = WINDOW_LEN_RST;
      wr_ptr   = 0;
      fill     = 0;
      errors   = 0;
      expected.delete();
    endfunction

    function int unsigned pending();
      return expected.size();
    endfunction

    function int unsigned active_length();
      if (win_len == 0) return 1;
      if (win_len > WINDOW_SLOTS) return WINDOW_SLOTS;
      return win_len;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_CAPACITY:    capacity = data;
        REG_STABLE_BAND: band = data;
        REG_WINDOW_LEN: begin
          // only a real change of length restarts the window
          if (data[LEN_W-1:0] != win_len) begin
            win_len = data[LEN_W-1:0];
            wr_ptr  = 0;
            fill    = 0;
          end
        end
        default: ;
      endcase
    endfunction

    function void note_request(logic kind, logic signed [WEIGHT_W-1:0] w);
      reading_t    r;
      int unsigned len;
      int          wv, cap_v, band_v, lo, hi;
      len    = active_length();
      wv     = w;
      cap_v  = capacity;
      band_v = band;
      if (kind == REQ_TARE) begin
        fill = 0;
        return;
      end
      r.weight   = w;
      r.overload = 1'b0;
      r.stable   = 1'b0;
      if (wv > cap_v) begin
        fill       = 0;
        r.overload = 1'b1;
      end else begin
        if (wr_ptr >= len) wr_ptr = 0;
        window[wr_ptr] = w;
        wr_ptr = (wr_ptr + 1) % len;
        if (fill < len) fill++;
        if (fill >= len) begin
          lo = window[0];
          hi = window[0];
          for (int i = 1; i < len; i++) begin
            if (int'(window[i]) < lo) lo = window[i];
            if (int'(window[i]) > hi) hi = window[i];
          end
          r.stable = (hi - lo <= band_v);
        end
      end
      expected.push_back(r);
    endfunction

    function void check_result(logic signed [WEIGHT_W-1:0] w, logic ov, logic st);
      reading_t r;
      if (expected.size() == 0) begin
        $display("%0t: result with none outstanding: weight %0d overload %0b stable %0b",
                 $time, w, ov, st);
        errors++;
        return;
      end
      r = expected.pop_front();
      if (w !== r.weight) begin
        $display("%0t: weight_out expected %0d actual %0d", $time, r.weight, w);
        errors++;
      end
      if (ov !== r.overload) begin
        $display("%0t: overload expected %0b actual %0b", $time, r.overload, ov);
        errors++;
      end
      if (st !== r.stable) begin
        $display("%0t: stable expected %0b actual %0b", $time, r.stable, st);
        errors++;
      end
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_idx_i = REG_CAPACITY;
  logic [CFG_W-1:0]           cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic                       req_type_i = REQ_SAMPLE;
  logic signed [WEIGHT_W-1:0] weight_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [WEIGHT_W-1:0] weight_out_o;
  logic                       overload_o;
  logic                       stable_o;

  int unsigned send_idle_pct = 36;
  int unsigned recv_idle_pct = 64;
  int unsigned quiet_cycles = 0;

  stability_scoreboard sb;

  // register settings per phase: capacity, band, window length
  int unsigned cap_tab [PHASE_COUNT] = '{8388607, 0, 8388607, 500000, 8388607, 1000000,
                                         2000, 8388607, 0, 300000, 8388607, 7000000};
  int unsigned band_tab [PHASE_COUNT] = '{10, 5, 0, 8388607, 100, 50,
                                          20, 1000, 0, 30, 8388607, 15};
  int unsigned len_tab [PHASE_COUNT] = '{8, 3, 1, 16, 16, 20, 0, 5, 2, 12, 7, 16};

  logic dir_kind [DIRECTED_COUNT] = '{REQ_SAMPLE, REQ_SAMPLE, REQ_SAMPLE, REQ_SAMPLE,
                                      REQ_SAMPLE, REQ_SAMPLE, REQ_TARE, REQ_SAMPLE,
                                      REQ_SAMPLE, REQ_SAMPLE, REQ_SAMPLE, REQ_SAMPLE,
                                      REQ_SAMPLE, REQ_SAMPLE, REQ_SAMPLE, REQ_SAMPLE,
                                      REQ_SAMPLE, REQ_TARE, REQ_SAMPLE, REQ_SAMPLE,
                                      REQ_SAMPLE, REQ_SAMPLE};
  int dir_weight [DIRECTED_COUNT] = '{100, 105, 110, 101, 111, 90, -1, 1000,
                                      1001, 8388607, -8388608, -8388608, -8388608,
                                      -8388608, -8388607, 0, -1, 0, 5, 5, 5, 5};

  weight_stability_detector #(
    .WINDOW_DEPTH(WINDOW_SLOTS)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .weight_i    (weight_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .weight_out_o(weight_out_o),
    .overload_o  (overload_o),
    .stable_o    (stable_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // observe transfers on both channels and watch for a stuck block
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) sb.note_request(req_type_i, weight_i);
    if (out_valid_o && out_ready_i) sb.check_result(weight_out_o, overload_o, stable_o);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic signed [WEIGHT_W-1:0] to_weight(input int v);
    if (v > 8388607) v = 8388607;
    else if (v < -8388608) v = -8388608;
    return v[WEIGHT_W-1:0];
  endfunction

  function automatic int pick_base(input int span);
    case ($urandom_range(9))
      0, 1:    return -8388608 + int'($urandom_range(1000));
      2, 3:    return 8388607 - span - int'($urandom_range(1000));
      default: return int'($urandom_range(2000000)) - 1000000;
    endcase
  endfunction

  task automatic send_request(input logic kind, input logic signed [WEIGHT_W-1:0] w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    weight_i   <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // hold the request channel until the block has gone quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_config(input int unsigned cap, input int unsigned band,
                              input int unsigned len);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_CAPACITY;
    cfg_data_i <= cap[CFG_W-1:0];
    @(posedge clk_i);
    sb.write_reg(REG_CAPACITY, cap[CFG_W-1:0]);
    cfg_idx_i  <= REG_STABLE_BAND;
    cfg_data_i <= band[CFG_W-1:0];
    @(posedge clk_i);
    sb.write_reg(REG_STABLE_BAND, band[CFG_W-1:0]);
    cfg_idx_i  <= REG_WINDOW_LEN;
    cfg_data_i <= len[CFG_W-1:0];
    @(posedge clk_i);
    sb.write_reg(REG_WINDOW_LEN, len[CFG_W-1:0]);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned n_items);
    int          base, span, v, band_v, cap_v;
    int unsigned sent, pick, rnd;
    band_v = sb.band;
    cap_v  = sb.capacity;
    span   = (band_v > 50000) ? 50000 : band_v;
    base   = pick_base(span);
    sent   = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      rnd  = $urandom;
      if (pick < 4) begin
        send_request(REQ_TARE, rnd[WEIGHT_W-1:0]);
        sent++;
      end else if (pick < 8) begin
        send_request(REQ_SAMPLE, rnd[WEIGHT_W-1:0]);
        sent++;
      end else if (pick < 11) begin
        // just above the limit
        send_request(REQ_SAMPLE, to_weight(cap_v + 1 + int'($urandom_range(3))));
        sent++;
      end else if (pick < 14) begin
        base = pick_base(span);
      end else if (pick < 15) begin
        drain();
      end else begin
        // mostly within the band, now and then a little wider
        if ($urandom_range(4) == 0) v = base + int'($urandom_range(2 * span + 1));
        else v = base + int'($urandom_range(span));
        send_request(REQ_SAMPLE, to_weight(v));
        sent++;
      end
    end
  endtask

  initial begin
    sb = new;
    sb.clear();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apply_config(1000, 10, 4);
    for (int i = 0; i < DIRECTED_COUNT; i++) send_request(dir_kind[i], to_weight(dir_weight[i]));
    drain();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p < 4) begin
        send_idle_pct = 36;
        recv_idle_pct = 64;
      end else if (p < 8) begin
        send_idle_pct = 64;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_config(cap_tab[p], band_tab[p], len_tab[p]);
      run_phase(PHASE_ITEMS);
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
